/* hw/rtl/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and helper functions of the digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

    // geometry of the key square and the alphabet
    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;
    localparam int LETTER_W    = 5;
    localparam int FUNC_W      = 2;
    localparam int ROW_W       = 3;

    // letter codes with a special role
    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

    // function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_KEY    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PLAIN  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd3;

    // input item
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LETTER_W-1:0] letter;
    } pfe_in_t;

    // result item
    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                last;
    } pfe_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic key_step;
        logic fill_step;
        logic msg_step;
        logic out_load;
        logic out_second;
    } pfe_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              emit;
        logic              fill_last;
        logic              out_free;
    } pfe_status_t;

    // J shares the cell of I
    function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] l);
        return (l == CODE_J) ? CODE_I : l;
    endfunction

    // row of a cell index below CELLS
    function automatic logic [ROW_W-1:0] cell_row(input logic [LETTER_W-1:0] p);
        logic [ROW_W-1:0] r;
        priority if (p >= LETTER_W'(4 * SQUARE_SIDE)) begin
            r = ROW_W'(4);
        end else if (p >= LETTER_W'(3 * SQUARE_SIDE)) begin
            r = ROW_W'(3);
        end else if (p >= LETTER_W'(2 * SQUARE_SIDE)) begin
            r = ROW_W'(2);
        end else if (p >= LETTER_W'(SQUARE_SIDE)) begin
            r = ROW_W'(1);
        end else begin
            r = ROW_W'(0);
        end
        return r;
    endfunction

    // first cell of a row: four times the row plus the row
    function automatic logic [LETTER_W-1:0] row_base(input logic [ROW_W-1:0] r);
        return LETTER_W'({r, 2'b00}) + LETTER_W'(r);
    endfunction

    // step one place along a row or column, wrapping round
    function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
        return (v == ROW_W'(SQUARE_SIDE - 1)) ? ROW_W'(0) : v + ROW_W'(1);
    endfunction

endpackage

/* hw/rtl/pfe_ctrl.sv */
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: takes one item at a time and steps the datapath through key
// entry, square fill, digraph lookup and the two result letters.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfe_pkg::pfe_status_t status,
    output pfe_pkg::pfe_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_EMIT0 = 3'd5;
    localparam logic [2:0] ST_EMIT1 = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.func)
                    pfe_pkg::FUNC_KEY: begin
                        cmd.key_step = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    pfe_pkg::FUNC_FINISH: begin
                        state_next = ST_FILL;
                    end
                    default: begin
                        cmd.msg_step = 1'b1;
                        state_next   = status.emit ? ST_LOOK : ST_IDLE;
                    end
                endcase
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                state_next = ST_EMIT0;
            end
            ST_EMIT0: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_second = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/pfe_datapath.sv */
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square and position memories, used-letter map, digraph pairing state,
// cell lookup and the output register.
// ----------------------------------------------------------------------------
module pfe_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfe_pkg::pfe_in_t     s_data,
    input  pfe_pkg::pfe_cmd_t    cmd,
    output pfe_pkg::pfe_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pfe_pkg::pfe_out_t    m_data
);

    localparam int LW = pfe_pkg::LETTER_W;
    localparam int RW = pfe_pkg::ROW_W;

    // memories
    logic [LW-1:0] key_square_mem [pfe_pkg::CELLS];
    logic [LW-1:0] letter_pos_mem [pfe_pkg::LETTERS];

    // registers
    pfe_pkg::pfe_in_t             item_reg;
    logic [pfe_pkg::LETTERS-1:0]  used_reg, used_next;
    logic [LW-1:0]                fill_reg, fill_next;
    logic [LW-1:0]                fill_idx_reg;
    logic [LW-1:0]                pend_letter_reg, pend_letter_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [LW-1:0]                prev_letter_reg, prev_letter_next;
    logic                         prev_valid_reg, prev_valid_next;
    logic [LW-1:0]                pair_a_reg, pair_a_next;
    logic [LW-1:0]                pair_b_reg, pair_b_next;
    logic [LW-1:0]                pos_a_reg, pos_b_reg;
    logic [LW-1:0]                ciph_a_reg, ciph_b_reg;
    logic                         m_valid_reg;
    pfe_pkg::pfe_out_t            m_data_reg;

    // combinational
    logic          letter_ok;
    logic [LW-1:0] key_letter;
    logic          place_en;
    logic [LW-1:0] place_letter;
    logic          emit;
    logic          insert_z;
    logic [LW-1:0] pa, pb, x_idx, y_idx;
    logic [RW-1:0] ra, rb, ca, cb;

    assign letter_ok  = (item_reg.letter < LW'(pfe_pkg::LETTERS));
    assign key_letter = pfe_pkg::fold(item_reg.letter);

    // placement of one letter into the next free cell
    always_comb begin
        place_en     = 1'b0;
        place_letter = key_letter;
        if (cmd.key_step) begin
            place_en = letter_ok && !used_reg[key_letter]
                       && (fill_reg < LW'(pfe_pkg::CELLS));
        end else if (cmd.fill_step) begin
            place_letter = fill_idx_reg;
            place_en     = (fill_idx_reg != pfe_pkg::CODE_J) && !used_reg[fill_idx_reg]
                           && (fill_reg < LW'(pfe_pkg::CELLS));
        end
    end

    // used-letter map and fill count; the finishing sweep clears both
    always_comb begin
        used_next = used_reg;
        fill_next = fill_reg;
        if (place_en) begin
            used_next = used_reg | (pfe_pkg::LETTERS'(1) << place_letter);
            fill_next = fill_reg + LW'(1);
        end
        if (cmd.fill_step && status.fill_last) begin
            used_next = '0;
            fill_next = '0;
        end
    end

    // pairing of plaintext letters, filler insertion and end of message
    assign insert_z = prev_valid_reg && (prev_letter_reg == item_reg.letter);

    always_comb begin
        emit             = 1'b0;
        pair_a_next      = pend_letter_reg;
        pair_b_next      = item_reg.letter;
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        prev_letter_next = prev_letter_reg;
        prev_valid_next  = prev_valid_reg;
        if (item_reg.func == pfe_pkg::FUNC_END) begin
            emit             = pend_valid_reg;
            pair_b_next      = pfe_pkg::CODE_Z;
            pend_letter_next = '0;
            pend_valid_next  = 1'b0;
            prev_letter_next = '0;
            prev_valid_next  = 1'b0;
        end else if (letter_ok) begin
            prev_letter_next = item_reg.letter;
            prev_valid_next  = 1'b1;
            priority if (insert_z && pend_valid_reg) begin
                emit             = 1'b1;
                pair_b_next      = pfe_pkg::CODE_Z;
                pend_letter_next = item_reg.letter;
            end else if (insert_z) begin
                emit        = 1'b1;
                pair_a_next = pfe_pkg::CODE_Z;
            end else if (pend_valid_reg) begin
                emit            = 1'b1;
                pend_valid_next = 1'b0;
            end else begin
                pend_letter_next = item_reg.letter;
                pend_valid_next  = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg        <= '0;
            fill_reg        <= '0;
            fill_idx_reg    <= '0;
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            prev_letter_reg <= '0;
            prev_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            used_reg <= used_next;
            fill_reg <= fill_next;
            if (cmd.capture) begin
                fill_idx_reg <= '0;
            end else if (cmd.fill_step) begin
                fill_idx_reg <= fill_idx_reg + LW'(1);
            end
            if (cmd.msg_step) begin
                pend_letter_reg <= pend_letter_next;
                pend_valid_reg  <= pend_valid_next;
                prev_letter_reg <= prev_letter_next;
                prev_valid_reg  <= prev_valid_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.msg_step) begin
            pair_a_reg <= pair_a_next;
            pair_b_reg <= pair_b_next;
        end
        if (cmd.out_load) begin
            m_data_reg.cipher_letter <= cmd.out_second ? ciph_b_reg : ciph_a_reg;
            m_data_reg.last          <= cmd.out_second;
        end
    end

    // position memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (place_en) begin
            letter_pos_mem[place_letter] <= fill_reg;
        end
        pos_a_reg <= letter_pos_mem[pfe_pkg::fold(pair_a_reg)];
        pos_b_reg <= letter_pos_mem[pfe_pkg::fold(pair_b_reg)];
    end

    // digraph rules: same row, same column, rectangle
    always_comb begin
        pa = (pos_a_reg < LW'(pfe_pkg::CELLS)) ? pos_a_reg : '0;
        pb = (pos_b_reg < LW'(pfe_pkg::CELLS)) ? pos_b_reg : '0;
        ra = pfe_pkg::cell_row(pa);
        rb = pfe_pkg::cell_row(pb);
        ca = RW'(pa - pfe_pkg::row_base(ra));
        cb = RW'(pb - pfe_pkg::row_base(rb));
        priority if (ra == rb) begin
            x_idx = pfe_pkg::row_base(ra) + LW'(pfe_pkg::wrap_inc(ca));
            y_idx = pfe_pkg::row_base(rb) + LW'(pfe_pkg::wrap_inc(cb));
        end else if (ca == cb) begin
            x_idx = pfe_pkg::row_base(pfe_pkg::wrap_inc(ra)) + LW'(ca);
            y_idx = pfe_pkg::row_base(pfe_pkg::wrap_inc(rb)) + LW'(cb);
        end else begin
            x_idx = pfe_pkg::row_base(ra) + LW'(cb);
            y_idx = pfe_pkg::row_base(rb) + LW'(ca);
        end
    end

    // key square memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (place_en) begin
            key_square_mem[fill_reg] <= place_letter;
        end
        ciph_a_reg <= key_square_mem[x_idx];
        ciph_b_reg <= key_square_mem[y_idx];
    end

    // status to the controller
    assign status.func      = item_reg.func;
    assign status.emit      = emit;
    assign status.fill_last = (fill_idx_reg == LW'(pfe_pkg::LETTERS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/playfair_digraph_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_unit
// Playfair encryptor with a 5x5 key square, one item in flight at a time.
// ----------------------------------------------------------------------------
// Input items (s_valid/s_ready/s_data) carry func and letter: key letters,
// a finish-key command, plaintext letters and end of message. Results
// (m_valid/m_ready/m_data) are ciphertext letters, two per digraph, with
// last set on the second.
// Work per item, from acceptance to the next acceptance:
//   key letter or plaintext letter that only opens a digraph: an execute step
//   plaintext letter or end of message that closes a digraph: the results come
//     out after the position lookup and the key square lookup, each through
//     a registered memory read
//   finish key: one alphabet letter a cycle through the fill sweep
// A letter code above 25 is dropped with no result.
// Reset clears the used-letter map, the fill count, the digraph state and
// the output valid flag; the key square holds nothing until a key is loaded.
// A stalled receiver holds the block in its emit step; the last result sits
// in the output register while the next item is already taken.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfe_pkg::pfe_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pfe_pkg::pfe_out_t m_data
);

    pfe_pkg::pfe_cmd_t    cmd;
    pfe_pkg::pfe_status_t status;

    // sequencer
    pfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    pfe_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // only one item at a time: an accepted item closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // a result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // datapath steps never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.key_step, cmd.fill_step, cmd.msg_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // the second letter of a digraph follows a first one
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && cmd.out_second |-> m_valid && !m_data.last || !m_valid)
        else $error("second letter without a first");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Playfair digraph encryptor. A shadow of the key
// square and the message state works out the cipher letters of every item
// taken, and each result is checked against the oldest one still due.
// ----------------------------------------------------------------------------
module testbench;
    import pfe_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int PHASE_ITEMS = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_MAX  = 10;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pfe_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pfe_out_t m_data;

    // shadow of the key square and the message state
    logic [LETTER_W-1:0] shadow_cell [CELLS];
    logic [LETTER_W-1:0] shadow_pos [LETTERS];
    logic [LETTERS-1:0]  shadow_used = '0;
    int                  shadow_fill = 0;
    logic [LETTER_W-1:0] open_letter = '0;
    logic                open_valid = 1'b0;
    logic [LETTER_W-1:0] last_plain = '0;
    logic                last_plain_valid = 1'b0;

    // cipher letters still owed by the block, oldest first
    pfe_out_t cipher_due [$];

    int fault_count   = 0;
    int taken_count   = 0;
    int idle_cycles   = 0;
    int item_budget   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    playfair_digraph_encrypt_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // J shares the cell of I
    function automatic logic [LETTER_W-1:0] merge_j(input logic [LETTER_W-1:0] l);
        return (l == CODE_J) ? CODE_I : l;
    endfunction

    function automatic void place_letter(input logic [LETTER_W-1:0] l);
        if (shadow_fill < CELLS) begin
            shadow_cell[shadow_fill] = l;
            shadow_pos[l]            = LETTER_W'(shadow_fill);
            shadow_used[l]           = 1'b1;
            shadow_fill++;
        end
    endfunction

    // same row: shift right, same column: shift down, else swap columns
    function automatic void encipher_pair(input logic [LETTER_W-1:0] a,
                                          input logic [LETTER_W-1:0] b);
        int pa, pb, ra, ca, rb, cb, xa, xb;
        pa = int'(shadow_pos[merge_j(a)]);
        pb = int'(shadow_pos[merge_j(b)]);
        if (pa >= CELLS) pa = 0;
        if (pb >= CELLS) pb = 0;
        ra = pa / SQUARE_SIDE;
        ca = pa % SQUARE_SIDE;
        rb = pb / SQUARE_SIDE;
        cb = pb % SQUARE_SIDE;
        if (ra == rb) begin
            xa = ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE;
            xb = rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE;
        end else if (ca == cb) begin
            xa = ((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca;
            xb = ((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb;
        end else begin
            xa = ra * SQUARE_SIDE + cb;
            xb = rb * SQUARE_SIDE + ca;
        end
        cipher_due.push_back(pfe_out_t'{cipher_letter: shadow_cell[xa], last: 1'b0});
        cipher_due.push_back(pfe_out_t'{cipher_letter: shadow_cell[xb], last: 1'b1});
    endfunction

    // a plaintext letter either opens a digraph or closes it
    function automatic void take_plain(input logic [LETTER_W-1:0] l);
        if (open_valid) begin
            open_valid = 1'b0;
            encipher_pair(open_letter, l);
        end else begin
            open_letter = l;
            open_valid  = 1'b1;
        end
    endfunction

    function automatic void encipher_item(input pfe_in_t it);
        logic [LETTER_W-1:0] l;
        l = it.letter;
        case (it.func)
            FUNC_KEY: begin
                if (l < LETTERS && !shadow_used[merge_j(l)]) place_letter(merge_j(l));
            end
            FUNC_FINISH: begin
                for (int k = 0; k < LETTERS; k++) begin
                    if (LETTER_W'(k) != CODE_J && !shadow_used[k]) place_letter(LETTER_W'(k));
                end
                shadow_used = '0;
                shadow_fill = 0;
            end
            FUNC_PLAIN: begin
                if (l < LETTERS) begin
                    if (last_plain_valid && last_plain == l) take_plain(CODE_Z);
                    take_plain(l);
                    last_plain       = l;
                    last_plain_valid = 1'b1;
                end
            end
            FUNC_END: begin
                if (open_valid) encipher_pair(open_letter, CODE_Z);
                open_letter      = '0;
                open_valid       = 1'b0;
                last_plain       = '0;
                last_plain_valid = 1'b0;
            end
        endcase
    endfunction

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result check, prediction of taken items and watchdog
    always @(posedge aclk) begin
        pfe_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cipher_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected result: letter %0d last %0b",
                                 m_data.cipher_letter, m_data.last);
                end else begin
                    want = cipher_due.pop_front();
                    if (m_data.cipher_letter !== want.cipher_letter ||
                        m_data.last !== want.last) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("mismatch: expected letter %0d last %0b, got letter %0d last %0b",
                                     want.cipher_letter, want.last,
                                     m_data.cipher_letter, m_data.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                encipher_item(s_data);
                taken_count++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // offer one item and hold it until taken; an idle gap may follow
    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [LETTER_W-1:0] ch);
        int seen;
        seen = taken_count;
        s_valid <= 1'b1;
        s_data  <= pfe_in_t'{func: op, letter: ch};
        do @(negedge aclk); while (taken_count == seen);
        if (op == FUNC_FINISH || op == FUNC_END || ch < LETTERS) item_budget++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    // sender stays quiet until every owed letter has come out
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (cipher_due.size() != 0);
    endtask

    // mostly valid letters, now and then a code above Z
    function automatic logic [LETTER_W-1:0] pick_letter();
        if ($urandom_range(0, 24) == 0) return LETTER_W'($urandom_range(LETTERS, 31));
        return LETTER_W'($urandom_range(0, LETTERS - 1));
    endfunction

    function automatic logic [LETTER_W-1:0] any_code();
        return LETTER_W'($urandom_range(0, 31));
    endfunction

    // key rules: J folds to I, repeats and bad codes are dropped
    task automatic test_key_load();
        send_item(FUNC_KEY, CODE_J);
        send_item(FUNC_KEY, CODE_I);
        send_item(FUNC_KEY, 5'd31);
        send_item(FUNC_KEY, 5'd26);
        send_item(FUNC_KEY, CODE_Z);
        send_item(FUNC_KEY, 5'd0);
        send_item(FUNC_KEY, 5'd15);
        send_item(FUNC_FINISH, 5'd31);
    endtask

    // fillers between equal letters, I with J, ZZ, row, column and rectangle
    task automatic test_digraph_rules();
        send_item(FUNC_PLAIN, 5'd31);
        send_item(FUNC_PLAIN, 5'd0);
        send_item(FUNC_PLAIN, 5'd0);
        send_item(FUNC_PLAIN, CODE_J);
        send_item(FUNC_PLAIN, CODE_I);
        send_item(FUNC_PLAIN, CODE_Z);
        send_item(FUNC_PLAIN, CODE_Z);
        send_item(FUNC_PLAIN, 5'd2);
        send_item(FUNC_PLAIN, 5'd3);
        send_item(FUNC_PLAIN, CODE_Z);
        send_item(FUNC_PLAIN, 5'd3);
        send_item(FUNC_PLAIN, 5'd10);
        send_item(FUNC_PLAIN, 5'd19);
    endtask

    // odd message padded with Z, then end with nothing open
    task automatic test_end_of_message();
        send_item(FUNC_PLAIN, 5'd24);
        send_item(FUNC_END, 5'd0);
        send_item(FUNC_END, 5'd31);
        send_item(FUNC_PLAIN, 5'd23);
        send_item(FUNC_END, 5'd12);
    endtask

    // a fresh key: short and random, or every letter in shuffled order
    task automatic random_key();
        logic [LETTER_W-1:0] order [LETTERS];
        logic [LETTER_W-1:0] swap;
        int j;
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < LETTERS; k++) order[k] = LETTER_W'(k);
            for (int k = LETTERS - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                swap     = order[k];
                order[k] = order[j];
                order[j] = swap;
            end
            foreach (order[k]) send_item(FUNC_KEY, order[k]);
            repeat ($urandom_range(1, 3)) send_item(FUNC_KEY, pick_letter());
        end else begin
            repeat ($urandom_range(0, 12)) send_item(FUNC_KEY, pick_letter());
        end
        if ($urandom_range(0, 9) != 0) send_item(FUNC_FINISH, any_code());
    endtask

    // a message with frequent doubled letters and a little noise
    task automatic random_message();
        logic [LETTER_W-1:0] prev_sent, ch;
        prev_sent = LETTER_W'($urandom_range(0, LETTERS - 1));
        repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 49))
                0: send_item(FUNC_KEY, pick_letter());
                1: send_item(FUNC_FINISH, any_code());
                2: send_item(FUNC_END, any_code());
                3, 4: send_item(FUNC_PLAIN, pick_letter());
                default: begin
                    ch = ($urandom_range(0, 3) == 0) ? prev_sent
                                                     : LETTER_W'($urandom_range(0, LETTERS - 1));
                    send_item(FUNC_PLAIN, ch);
                    prev_sent = ch;
                end
            endcase
        end
        if ($urandom_range(0, 6) != 0) send_item(FUNC_END, any_code());
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int stop_at;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at = item_budget + PHASE_ITEMS;
        while (item_budget < stop_at && item_budget < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) random_key();
            random_message();
        end
        wait_drain();
    endtask

    // receiver holds off while letters keep coming, so the input stalls
    task automatic test_receiver_hold();
        wait_drain();
        hold_request = LONG_HOLD;
        repeat (24) send_item(FUNC_PLAIN, LETTER_W'($urandom_range(0, LETTERS - 1)));
        send_item(FUNC_END, any_code());
        wait_drain();
    endtask

    // test sequence
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 16;
        recv_idle_pct = 75;
        test_key_load();
        test_digraph_rules();
        test_end_of_message();
        wait_drain();

        test_random_traffic(16, 75);
        test_receiver_hold();
        test_random_traffic(75, 16);
        test_random_traffic(0, 0);

        wait_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
